[rtl/hocpg_pkg.sv]
// shared types, constants and microcode for the hopf pattern generator
package hocpg_pkg;

   localparam int FRAC_BITS = 24;
   localparam int OPW       = 33;
   localparam int PRODW     = 2 * OPW;
   localparam int ACCW      = 64;
   localparam int TIMEW     = 48;
   localparam int TICKW     = 32;
   localparam int STEP_W    = 5;

   localparam logic signed [31:0] Q_ONE     = 32'(longint'(1) << FRAC_BITS);
   localparam logic signed [31:0] OSC_INIT  = 32'(((longint'(1) << FRAC_BITS) + 5) / 10);
   localparam logic signed [31:0] MU_INIT   =
      32'((78 * (longint'(1) << FRAC_BITS) + 50) / 100);
   localparam logic signed [31:0] OMEGA_INIT =
      32'((21 * (longint'(1) << FRAC_BITS) + 5) / 10);
   localparam logic [30:0]        SLOPE_INIT = 31'(((longint'(1) << FRAC_BITS) + 15) / 30);
   localparam logic [15:0]        GAIN_INIT  = 16'd5000;
   localparam logic [31:0]        START_INIT = 32'd3000;
   localparam logic [31:0]        STOP_INIT  = 32'd30000;
   localparam logic [31:0]        RAMP_INIT  = 32'd2000;

   // microcode step numbers the sequencer cares about
   localparam logic [STEP_W-1:0] STEP_NY_LAST = 5'd23;
   localparam logic [STEP_W-1:0] STEP_VX      = 5'd26;
   localparam logic [STEP_W-1:0] STEP_LAST    = 5'd29;

   typedef enum logic [2:0] {
      CSR_MU, CSR_OMEGA, CSR_GAIN, CSR_START, CSR_STOP, CSR_RAMP, CSR_SLOPE
   } csr_index_type;

   typedef enum logic [1:0] {
      RUN_IDLE    = 2'd0,
      RUN_ACTIVE  = 2'd1,
      RUN_STOPPED = 2'd2
   } run_status_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EVAL, ST_MUL, ST_ACC, ST_DONE
   } seq_state_type;

   typedef enum logic [4:0] {
      OP_X, OP_Y, OP_MU, OP_OM, OP_ONE, OP_A, OP_DX, OP_DY, OP_RR, OP_RDR,
      OP_M, OP_DDX, OP_DDY, OP_H, OP_H2, OP_NEG2, OP_NX, OP_NY, OP_FAC,
      OP_VX, OP_VY, OP_GAIN, OP_LO, OP_HI, OP_SLOPE
   } opnd_type;

   typedef enum logic [2:0] {
      SH_F, SH_F1, SH_ZERO, SH_DRV, SH_RAWF, SH_RAW0
   } shift_type;

   typedef enum logic [4:0] {
      DST_NONE, DST_RR, DST_A, DST_DX, DST_DY, DST_RDR, DST_M, DST_DDX,
      DST_DDY, DST_H2, DST_NX, DST_NY, DST_FAC, DST_VX, DST_VY, DST_DRX,
      DST_DRY
   } dest_type;

   typedef struct packed {
      opnd_type  op_a;
      opnd_type  op_b;
      shift_type shift;
      logic      neg;
      logic      first;
      logic      last;
      dest_type  dest;
   } uop_type;

   typedef struct packed {
      logic              accept;
      logic              mul_en;
      logic              acc_en;
      logic [STEP_W-1:0] step;
      logic              load_out;
   } cmd_type;

   typedef struct packed {
      logic running;
      logic ramp;
   } stat_type;

   function automatic uop_type mk(input opnd_type a, input opnd_type b,
                                  input shift_type sh, input logic neg,
                                  input logic first, input logic last,
                                  input dest_type d);
      uop_type u;
      u.op_a  = a;
      u.op_b  = b;
      u.shift = sh;
      u.neg   = neg;
      u.first = first;
      u.last  = last;
      u.dest  = d;
      return u;
   endfunction

   function automatic uop_type uop_rom(input logic [STEP_W-1:0] step);
      uop_type u;
      case (step)
         5'd0:    u = mk(OP_X,    OP_X,     SH_F,    1'b0, 1'b1, 1'b0, DST_NONE);
         5'd1:    u = mk(OP_Y,    OP_Y,     SH_F,    1'b0, 1'b0, 1'b1, DST_RR);
         5'd2:    u = mk(OP_MU,   OP_ONE,   SH_F,    1'b0, 1'b1, 1'b0, DST_NONE);
         5'd3:    u = mk(OP_RR,   OP_ONE,   SH_F,    1'b1, 1'b0, 1'b1, DST_A);
         5'd4:    u = mk(OP_A,    OP_X,     SH_F,    1'b0, 1'b1, 1'b0, DST_NONE);
         5'd5:    u = mk(OP_OM,   OP_Y,     SH_F,    1'b1, 1'b0, 1'b1, DST_DX);
         5'd6:    u = mk(OP_A,    OP_Y,     SH_F,    1'b0, 1'b1, 1'b0, DST_NONE);
         5'd7:    u = mk(OP_OM,   OP_X,     SH_F,    1'b0, 1'b0, 1'b1, DST_DY);
         5'd8:    u = mk(OP_X,    OP_DX,    SH_F,    1'b0, 1'b1, 1'b0, DST_NONE);
         5'd9:    u = mk(OP_Y,    OP_DY,    SH_F,    1'b0, 1'b0, 1'b1, DST_RDR);
         5'd10:   u = mk(OP_RDR,  OP_NEG2,  SH_ZERO, 1'b0, 1'b1, 1'b1, DST_M);
         5'd11:   u = mk(OP_M,    OP_X,     SH_F,    1'b0, 1'b1, 1'b0, DST_NONE);
         5'd12:   u = mk(OP_A,    OP_DX,    SH_F,    1'b0, 1'b0, 1'b0, DST_NONE);
         5'd13:   u = mk(OP_OM,   OP_DY,    SH_F,    1'b1, 1'b0, 1'b1, DST_DDX);
         5'd14:   u = mk(OP_M,    OP_Y,     SH_F,    1'b0, 1'b1, 1'b0, DST_NONE);
         5'd15:   u = mk(OP_A,    OP_DY,    SH_F,    1'b0, 1'b0, 1'b0, DST_NONE);
         5'd16:   u = mk(OP_OM,   OP_DX,    SH_F,    1'b0, 1'b0, 1'b1, DST_DDY);
         5'd17:   u = mk(OP_H,    OP_H,     SH_F,    1'b0, 1'b1, 1'b1, DST_H2);
         5'd18:   u = mk(OP_X,    OP_ONE,   SH_F,    1'b0, 1'b1, 1'b0, DST_NONE);
         5'd19:   u = mk(OP_DX,   OP_H,     SH_F,    1'b0, 1'b0, 1'b0, DST_NONE);
         5'd20:   u = mk(OP_DDX,  OP_H2,    SH_F1,   1'b0, 1'b0, 1'b1, DST_NX);
         5'd21:   u = mk(OP_Y,    OP_ONE,   SH_F,    1'b0, 1'b1, 1'b0, DST_NONE);
         5'd22:   u = mk(OP_DY,   OP_H,     SH_F,    1'b0, 1'b0, 1'b0, DST_NONE);
         5'd23:   u = mk(OP_DDY,  OP_H2,    SH_F1,   1'b0, 1'b0, 1'b1, DST_NY);
         5'd24:   u = mk(OP_LO,   OP_SLOPE, SH_RAWF, 1'b0, 1'b1, 1'b0, DST_NONE);
         5'd25:   u = mk(OP_HI,   OP_SLOPE, SH_RAW0, 1'b0, 1'b0, 1'b1, DST_FAC);
         5'd26:   u = mk(OP_NX,   OP_FAC,   SH_F,    1'b0, 1'b1, 1'b1, DST_VX);
         5'd27:   u = mk(OP_NY,   OP_FAC,   SH_F,    1'b0, 1'b1, 1'b1, DST_VY);
         5'd28:   u = mk(OP_GAIN, OP_VX,    SH_DRV,  1'b0, 1'b1, 1'b1, DST_DRX);
         5'd29:   u = mk(OP_GAIN, OP_VY,    SH_DRV,  1'b0, 1'b1, 1'b1, DST_DRY);
         default: u = mk(OP_X,    OP_X,     SH_F,    1'b0, 1'b1, 1'b0, DST_NONE);
      endcase
      return u;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [PRODW-1:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

[rtl/hocpg_ctrl.sv]
// sequencer for the hopf pattern generator: handshakes and microcode stepping
module hocpg_ctrl import hocpg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   seq_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      req_ready    = 1'b0;
      cmd.accept   = 1'b0;
      cmd.mul_en   = 1'b0;
      cmd.acc_en   = 1'b0;
      cmd.load_out = 1'b0;
      cmd.step     = step_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EVAL;
            end
         end
         ST_EVAL: begin
            step_in  = '0;
            state_in = stat.running ? ST_MUL : ST_DONE;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_DONE;
            end else begin
               // no ramp: skip the ramp factor steps
               step_in  = (step_ff == STEP_NY_LAST && !stat.ramp) ? STEP_VX
                                                                  : step_ff + STEP_W'(1);
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken result");

   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC && step_ff == STEP_LAST) |=> state_ff == ST_DONE)
      else $error("sequencer missed the end of the microcode");

   a_idle_skips_math: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL && !stat.running) |=> state_ff == ST_DONE)
      else $error("oscillator stepped outside the active window");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL || state_ff == ST_ACC) |-> !req_ready)
      else $error("transfer taken while the datapath is busy");

endmodule

[rtl/hocpg_dpath.sv]
// datapath: settings, oscillator state, shared multiplier and accumulator
module hocpg_dpath import hocpg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic [30:0]        req_time_step,
   input  cmd_type            cmd,
   output stat_type           stat,
   output logic signed [31:0] rsp_drive_x,
   output logic signed [31:0] rsp_drive_y,
   output logic [1:0]         rsp_run_status
);

   logic signed [31:0] mu_ff, omega_ff;
   logic [15:0]        gain_ff;
   logic [31:0]        start_ff, stop_ff, rampt_ff;
   logic [30:0]        slope_ff;

   logic signed [31:0] osc_x_ff, osc_y_ff;
   logic [TICKW-1:0]   tick_ff, tick_in;
   logic [TIMEW-1:0]   elapsed_ff, elapsed_in;
   logic [TIMEW:0]     elapsed_sum;
   logic [30:0]        h_ff;
   run_status_type     status_ff, status_in;
   logic               ramp_ff;

   logic signed [31:0] rr_ff, a_ff, dx_ff, dy_ff, rdr_ff, m_ff, ddx_ff, ddy_ff;
   logic signed [31:0] h2_ff, nx_ff, ny_ff, fac_ff, vx_ff, vy_ff, drx_ff, dry_ff;

   logic signed [PRODW-1:0] prod_ff, rnd, rounded;
   logic signed [ACCW-1:0]  acc_ff, acc_in, term, capped;
   logic signed [OPW-1:0]   opa, opb;
   logic signed [31:0]      dest_val, fac_val;
   logic signed [31:0]      drv_x_out, drv_y_out;
   uop_type                 uop;
   int                      sh;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_ff    <= MU_INIT;
         omega_ff <= OMEGA_INIT;
         gain_ff  <= GAIN_INIT;
         start_ff <= START_INIT;
         stop_ff  <= STOP_INIT;
         rampt_ff <= RAMP_INIT;
         slope_ff <= SLOPE_INIT;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_MU:    mu_ff    <= csr_data;
            CSR_OMEGA: omega_ff <= csr_data;
            CSR_GAIN:  gain_ff  <= csr_data[15:0];
            CSR_START: start_ff <= csr_data;
            CSR_STOP:  stop_ff  <= csr_data;
            CSR_RAMP:  rampt_ff <= csr_data;
            CSR_SLOPE: slope_ff <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // tick bookkeeping, both counters saturate
   always_comb begin
      tick_in     = (tick_ff == '1) ? tick_ff : tick_ff + TICKW'(1);
      elapsed_sum = {1'b0, elapsed_ff} + (TIMEW + 1)'(req_time_step);
      elapsed_in  = elapsed_sum[TIMEW] ? '1 : elapsed_sum[TIMEW-1:0];
      if (tick_in >= stop_ff) begin
         status_in = RUN_STOPPED;
      end else if (tick_in > start_ff) begin
         status_in = RUN_ACTIVE;
      end else begin
         status_in = RUN_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         osc_x_ff   <= OSC_INIT;
         osc_y_ff   <= OSC_INIT;
         tick_ff    <= '0;
         elapsed_ff <= '0;
         status_ff  <= RUN_IDLE;
         ramp_ff    <= 1'b0;
      end else begin
         if (cmd.accept) begin
            tick_ff    <= tick_in;
            elapsed_ff <= elapsed_in;
            status_ff  <= status_in;
            ramp_ff    <= tick_in > rampt_ff;
         end
         if (cmd.load_out && status_ff == RUN_ACTIVE) begin
            osc_x_ff <= nx_ff;
            osc_y_ff <= ny_ff;
         end
      end
   end

   assign stat.running = (status_ff == RUN_ACTIVE);
   assign stat.ramp    = ramp_ff;

   assign uop = uop_rom(cmd.step);

   function automatic logic signed [OPW-1:0] pick(
      input opnd_type o,
      input logic signed [31:0] x, y, mu, om, a, dx, dy, rr, rdr, m,
      input logic signed [31:0] ddx, ddy, h2, nx, ny, fac, vx, vy,
      input logic [30:0] h, slope, input logic [15:0] gain,
      input logic [TIMEW-1:0] el);
      logic signed [OPW-1:0] r;
      case (o)
         OP_X:     r = OPW'(x);
         OP_Y:     r = OPW'(y);
         OP_MU:    r = OPW'(mu);
         OP_OM:    r = OPW'(om);
         OP_ONE:   r = OPW'(Q_ONE);
         OP_A:     r = OPW'(a);
         OP_DX:    r = OPW'(dx);
         OP_DY:    r = OPW'(dy);
         OP_RR:    r = OPW'(rr);
         OP_RDR:   r = OPW'(rdr);
         OP_M:     r = OPW'(m);
         OP_DDX:   r = OPW'(ddx);
         OP_DDY:   r = OPW'(ddy);
         OP_H:     r = OPW'(h);
         OP_H2:    r = OPW'(h2);
         OP_NEG2:  r = -OPW'(2);
         OP_NX:    r = OPW'(nx);
         OP_NY:    r = OPW'(ny);
         OP_FAC:   r = OPW'(fac);
         OP_VX:    r = OPW'(vx);
         OP_VY:    r = OPW'(vy);
         OP_GAIN:  r = OPW'(gain);
         OP_LO:    r = OPW'(el[FRAC_BITS-1:0]);
         OP_HI:    r = OPW'(el[TIMEW-1:FRAC_BITS]);
         OP_SLOPE: r = OPW'(slope);
         default:  r = '0;
      endcase
      return r;
   endfunction

   always_comb begin
      opa = pick(uop.op_a, osc_x_ff, osc_y_ff, mu_ff, omega_ff, a_ff, dx_ff, dy_ff,
                 rr_ff, rdr_ff, m_ff, ddx_ff, ddy_ff, h2_ff, nx_ff, ny_ff, fac_ff,
                 vx_ff, vy_ff, h_ff, slope_ff, gain_ff, elapsed_ff);
      opb = pick(uop.op_b, osc_x_ff, osc_y_ff, mu_ff, omega_ff, a_ff, dx_ff, dy_ff,
                 rr_ff, rdr_ff, m_ff, ddx_ff, ddy_ff, h2_ff, nx_ff, ny_ff, fac_ff,
                 vx_ff, vy_ff, h_ff, slope_ff, gain_ff, elapsed_ff);
   end

   // round half up, shift, saturate or keep raw, negate if asked, accumulate
   always_comb begin
      case (uop.shift)
         SH_F, SH_RAWF:   sh = FRAC_BITS;
         SH_F1:           sh = FRAC_BITS + 1;
         SH_DRV:          sh = FRAC_BITS - 16;
         SH_ZERO, SH_RAW0: sh = 0;
         default:         sh = 0;
      endcase
      rnd     = (sh == 0) ? '0 : (PRODW'(1) <<< (sh - 1));
      rounded = (prod_ff + rnd) >>> sh;
      if (uop.shift == SH_RAWF || uop.shift == SH_RAW0) begin
         term = rounded[ACCW-1:0];
      end else begin
         term = ACCW'(sat32(rounded));
      end
      if (uop.neg) begin
         term = -term;
      end
      acc_in   = (uop.first ? '0 : acc_ff) + term;
      dest_val = sat32(PRODW'(acc_in));
      capped   = (acc_in > (ACCW'(1) <<< 33)) ? (ACCW'(1) <<< 33) : acc_in;
      fac_val  = sat32(PRODW'(Q_ONE) - PRODW'(capped));
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         h_ff   <= req_time_step;
         fac_ff <= Q_ONE;
      end
      if (cmd.mul_en) begin
         prod_ff <= PRODW'(opa) * PRODW'(opb);
      end
      if (cmd.acc_en) begin
         acc_ff <= acc_in;
         if (uop.last) begin
            case (uop.dest)
               DST_RR:  rr_ff  <= dest_val;
               DST_A:   a_ff   <= dest_val;
               DST_DX:  dx_ff  <= dest_val;
               DST_DY:  dy_ff  <= dest_val;
               DST_RDR: rdr_ff <= dest_val;
               DST_M:   m_ff   <= dest_val;
               DST_DDX: ddx_ff <= dest_val;
               DST_DDY: ddy_ff <= dest_val;
               DST_H2:  h2_ff  <= dest_val;
               DST_NX:  nx_ff  <= dest_val;
               DST_NY:  ny_ff  <= dest_val;
               DST_FAC: fac_ff <= fac_val;
               DST_VX:  vx_ff  <= dest_val;
               DST_VY:  vy_ff  <= dest_val;
               DST_DRX: drx_ff <= dest_val;
               DST_DRY: dry_ff <= dest_val;
               default: ;
            endcase
         end
      end
   end

   assign drv_x_out = (status_ff == RUN_ACTIVE) ? drx_ff : '0;
   assign drv_y_out = (status_ff == RUN_ACTIVE) ? dry_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_drive_x    <= drv_x_out;
         rsp_drive_y    <= drv_y_out;
         rsp_run_status <= status_ff;
      end
   end

endmodule

[rtl/hopf_oscillator_cpg_step.sv]
// top level of the hopf oscillator pattern generator
//
// one request transfer is one control tick carrying its time step (unsigned q7.24);
// one response transfer carries drive_x, drive_y (q16.16, saturated) and
// the run status (idle, running, stopped)
// settings are written on the csr channel (always ready); the user must
// do so only while idle (unchecked); an unknown register index is ignored
// an item in the active window runs 30 microcode steps on one shared
// 33x33 multiplier, each step a multiply, then a round/accumulate; the
// ramp factor steps are skipped when that factor is not needed, and an
// idle or stopped tick runs no microcode, only accept, evaluate and load
// the response sits in its own output register, so a new request transfer
// is taken while an earlier result still waits; if the receiver stalls,
// the next result waits in the datapath until the output register frees
// reset (synchronous, active high) restores the default settings, puts the
// oscillator back to 0.1, 0.1 and clears the tick count and elapsed time
module hopf_oscillator_cpg_step import hocpg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [30:0]        req_time_step,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_drive_x,
   output logic signed [31:0] rsp_drive_y,
   output logic [1:0]         rsp_run_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   // command and status between sequencer and datapath
   cmd_type  cmd;
   stat_type stat;

   hocpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   hocpg_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_time_step  (req_time_step),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_drive_x    (rsp_drive_x),
      .rsp_drive_y    (rsp_drive_y),
      .rsp_run_status (rsp_run_status)
   );

endmodule
